// ===== hw/rtl/gfaf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gfaf_pkg: shared definitions for the guest frame anti-spoofing filter
// widths, protocol constants, register indexes and per-frame state type
// ----------------------------------------------------------------------------
package gfaf_pkg;

    localparam int BYTE_W      = 8;
    localparam int MARK_W      = 32;
    localparam int MAC_W       = 48;
    localparam int IP_W        = 32;
    localparam int COUNT_W     = 16;
    localparam int KIND_W      = 16;
    localparam int HDR_LEN_W   = 6;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 48;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FILTER_ENABLE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PASS_MARK     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GUEST_MAC     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GUEST_IP      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_GATEWAY_IP    = 3'd4;

    // ethertypes
    localparam logic [KIND_W-1:0] KIND_IPV4 = 16'h0800;
    localparam logic [KIND_W-1:0] KIND_ARP  = 16'h0806;

    // frame geometry
    localparam logic [COUNT_W-1:0]   ETH_HDR_BYTES = 16'd14;
    localparam logic [COUNT_W-1:0]   IPV4_MIN_FRAME = 16'd34;
    localparam logic [COUNT_W-1:0]   ARP_MIN_FRAME  = 16'd42;
    localparam logic [HDR_LEN_W-1:0] IP_MIN_HDR    = 6'd20;
    localparam logic [HDR_LEN_W-1:0] IP_MAX_HDR    = 6'd60;
    localparam logic [COUNT_W-1:0]   COUNT_MAX     = 16'hffff;

    typedef struct packed {
        logic [COUNT_W-1:0]   byte_count;
        logic [KIND_W-1:0]    ether_kind;
        logic                 mac_checks_ok;
        logic [HDR_LEN_W-1:0] ip_header_len;
        logic                 ip_version_ok;
        logic [COUNT_W-1:0]   ip_total_len;
        logic                 ip_source_ok;
        logic                 arp_checks_ok;
    } frame_state_t;

    localparam frame_state_t FRAME_CLEAR = '{
        byte_count:    '0,
        ether_kind:    '0,
        mac_checks_ok: 1'b1,
        ip_header_len: '0,
        ip_version_ok: 1'b0,
        ip_total_len:  '0,
        ip_source_ok:  1'b1,
        arp_checks_ok: 1'b1
    };

    // byte idx of a mac in wire order, idx 0 is the most significant
    function automatic logic [BYTE_W-1:0] mac_byte(input logic [MAC_W-1:0] mac,
                                                  input logic [2:0] idx);
        logic [BYTE_W-1:0] b;
        begin
            case (idx)
                3'd0:    b = mac[47:40];
                3'd1:    b = mac[39:32];
                3'd2:    b = mac[31:24];
                3'd3:    b = mac[23:16];
                3'd4:    b = mac[15:8];
                3'd5:    b = mac[7:0];
                default: b = '0;
            endcase
            return b;
        end
    endfunction

    // byte idx of an ipv4 address in network order
    function automatic logic [BYTE_W-1:0] ip_byte(input logic [IP_W-1:0] ip,
                                                 input logic [1:0] idx);
        logic [BYTE_W-1:0] b;
        begin
            case (idx)
                2'd0:    b = ip[31:24];
                2'd1:    b = ip[23:16];
                2'd2:    b = ip[15:8];
                default: b = ip[7:0];
            endcase
            return b;
        end
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/gfaf_byte_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gfaf_byte_if: frame byte channel
// one frame byte per request, with an end-of-frame flag
// ----------------------------------------------------------------------------
interface gfaf_byte_if;
    logic                           valid;
    logic                           ready;
    logic [gfaf_pkg::BYTE_W-1:0]    frame_byte;
    logic                           last_byte;

    modport source (output valid, output frame_byte, output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/gfaf_verdict_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gfaf_verdict_if: verdict channel
// one pass/drop decision with its mark per request
// ----------------------------------------------------------------------------
interface gfaf_verdict_if;
    logic                           valid;
    logic                           ready;
    logic                           accept;
    logic [gfaf_pkg::MARK_W-1:0]    frame_mark;

    modport source (output valid, output accept, output frame_mark, input ready);
    modport sink   (input valid, input accept, input frame_mark, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/gfaf_cfg_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gfaf_cfg_if: configuration write channel
// register index and write data per request
// ----------------------------------------------------------------------------
interface gfaf_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [gfaf_pkg::CFG_INDEX_W-1:0]   index;
    logic [gfaf_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/guest_frame_antispoof_filter_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// guest_frame_antispoof_filter_unit: mac/ip anti-spoofing ingress filter
// checks each guest frame byte by byte and gives a pass/drop verdict
// ----------------------------------------------------------------------------
//
//  channel   role    request carries            when
//  -------   ------  -------------------------  ----------------------------
//  frame     sink    frame_byte, last_byte      one request per frame byte
//  verdict   source  accept, frame_mark         one request per frame end
//  cfg       sink    index, data                register write, always ready
//
//  one byte a cycle sustained while no verdict waits; a byte taken into the
//  input register is folded into the frame state as it moves on, and a last
//  byte loads the verdict register, which offers the verdict to the sink
//  asynchronous active-low reset clears config registers, frame state and
//  both valid flags
//  while a verdict waits, bytes keep flowing until the next last byte reaches
//  the input register; it is held there and the frame channel stalls until
//  the waiting verdict is taken
// ----------------------------------------------------------------------------
module guest_frame_antispoof_filter_unit (
    input  wire          clk,
    input  wire          rst_n,
    gfaf_byte_if.sink    frame,
    gfaf_verdict_if.source verdict,
    gfaf_cfg_if.sink     cfg
);

    // configuration registers
    logic                              filter_enable_reg;
    logic [gfaf_pkg::MARK_W-1:0]       pass_mark_reg;
    logic [gfaf_pkg::MAC_W-1:0]        guest_mac_reg;
    logic [gfaf_pkg::IP_W-1:0]         guest_ip_reg;
    logic [gfaf_pkg::IP_W-1:0]         gateway_ip_reg;

    // input register
    logic                              in_valid_reg;
    logic [gfaf_pkg::BYTE_W-1:0]       in_byte_reg;
    logic                              in_last_reg;
    logic                              in_advance;

    // per-frame state
    gfaf_pkg::frame_state_t            state_reg;
    gfaf_pkg::frame_state_t            state_next;
    gfaf_pkg::frame_state_t            upd;

    // result register
    logic                              out_valid_reg;
    logic                              out_accept_reg;
    logic [gfaf_pkg::MARK_W-1:0]       out_mark_reg;

    logic [gfaf_pkg::COUNT_W-1:0]      pos;
    logic [gfaf_pkg::BYTE_W-1:0]       b;
    logic [gfaf_pkg::COUNT_W-1:0]      avail;
    logic [gfaf_pkg::COUNT_W-1:0]      hdr_len_wide;
    logic                              ipv4_ok;
    logic                              arp_ok;
    logic                              verdict_ok;

    // config writes land at once; unknown indexes are ignored
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_enable_reg <= 1'b0;
            pass_mark_reg     <= '0;
            guest_mac_reg     <= '0;
            guest_ip_reg      <= '0;
            gateway_ip_reg    <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                gfaf_pkg::REG_FILTER_ENABLE: filter_enable_reg <= cfg.data[0];
                gfaf_pkg::REG_PASS_MARK:     pass_mark_reg     <= cfg.data[31:0];
                gfaf_pkg::REG_GUEST_MAC:     guest_mac_reg     <= cfg.data;
                gfaf_pkg::REG_GUEST_IP:      guest_ip_reg      <= cfg.data[31:0];
                gfaf_pkg::REG_GATEWAY_IP:    gateway_ip_reg    <= cfg.data[31:0];
                default:
                begin
                end
            endcase
        end
    end

    // the held byte moves on unless it closes a frame and the verdict slot is busy
    assign in_advance = in_valid_reg && (!in_last_reg || !out_valid_reg || verdict.ready);
    assign frame.ready = !in_valid_reg || in_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (frame.ready)
        begin
            in_valid_reg <= frame.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame.ready && frame.valid)
        begin
            in_byte_reg <= frame.frame_byte;
            in_last_reg <= frame.last_byte;
        end
    end

    // state update for the held byte at its position in the frame
    assign pos = state_reg.byte_count;
    assign b   = in_byte_reg;

    always_comb
    begin
        upd = state_reg;
        if (pos < 16'd6)
        begin
            // destination must be broadcast for arp
            if (b != 8'hff) upd.arp_checks_ok = 1'b0;
        end
        else if (pos < 16'd12)
        begin
            // source mac
            if (b != gfaf_pkg::mac_byte(guest_mac_reg, 3'(pos[2:0] - 3'd6)))
                upd.mac_checks_ok = 1'b0;
        end
        else if (pos == 16'd12)
        begin
            upd.ether_kind = {b, 8'h00};
        end
        else if (pos == 16'd13)
        begin
            upd.ether_kind = {state_reg.ether_kind[15:8], b};
        end
        else if (pos == 16'd14)
        begin
            // ipv4 version/ihl, arp htype high byte
            upd.ip_version_ok = (b[7:4] == 4'd4);
            upd.ip_header_len = {b[3:0], 2'b00};
            if (b != 8'h00) upd.arp_checks_ok = 1'b0;
        end
        else if (pos == 16'd15)
        begin
            if (b != 8'h01) upd.arp_checks_ok = 1'b0;
        end
        else if (pos == 16'd16)
        begin
            // ipv4 total length high byte, arp ptype high byte
            upd.ip_total_len = {b, 8'h00};
            if (b != 8'h08) upd.arp_checks_ok = 1'b0;
        end
        else if (pos == 16'd17)
        begin
            upd.ip_total_len = {state_reg.ip_total_len[15:8], b};
            if (b != 8'h00) upd.arp_checks_ok = 1'b0;
        end
        else if (pos == 16'd18)
        begin
            if (b != 8'h06) upd.arp_checks_ok = 1'b0;
        end
        else if (pos == 16'd19)
        begin
            if (b != 8'h04) upd.arp_checks_ok = 1'b0;
        end
        else if (pos == 16'd20)
        begin
            if (b != 8'h00) upd.arp_checks_ok = 1'b0;
        end
        else if (pos == 16'd21)
        begin
            // opcode must be request
            if (b != 8'h01) upd.arp_checks_ok = 1'b0;
        end
        else if (pos < 16'd28)
        begin
            // arp sender mac
            if (b != gfaf_pkg::mac_byte(guest_mac_reg, 3'(pos[2:0] - 3'd6)))
                upd.arp_checks_ok = 1'b0;
        end
        else if (pos < 16'd32)
        begin
            // arp sender ip
            if (b != gfaf_pkg::ip_byte(guest_ip_reg, pos[1:0]))
                upd.arp_checks_ok = 1'b0;
        end
        else if (pos < 16'd38)
        begin
            // arp target mac must be zero
            if (b != 8'h00) upd.arp_checks_ok = 1'b0;
        end
        else if (pos < 16'd42)
        begin
            // arp target ip
            if (b != gfaf_pkg::ip_byte(gateway_ip_reg, 2'(pos[1:0] - 2'd2)))
                upd.arp_checks_ok = 1'b0;
        end

        // ipv4 source address sits at frame bytes 26 to 29
        if (pos >= 16'd26 && pos < 16'd30)
        begin
            if (b != gfaf_pkg::ip_byte(guest_ip_reg, 2'(pos[1:0] - 2'd2)))
                upd.ip_source_ok = 1'b0;
        end

        // saturating byte count
        if (state_reg.byte_count != gfaf_pkg::COUNT_MAX)
            upd.byte_count = state_reg.byte_count + 16'd1;
    end

    // verdict on the updated state, count includes the held byte
    assign avail        = upd.byte_count - gfaf_pkg::ETH_HDR_BYTES;
    assign hdr_len_wide = {{(gfaf_pkg::COUNT_W-gfaf_pkg::HDR_LEN_W){1'b0}}, upd.ip_header_len};

    assign ipv4_ok = (upd.byte_count >= gfaf_pkg::IPV4_MIN_FRAME)
                  && upd.ip_version_ok
                  && (upd.ip_header_len >= gfaf_pkg::IP_MIN_HDR)
                  && (upd.ip_header_len <= gfaf_pkg::IP_MAX_HDR)
                  && (hdr_len_wide <= avail)
                  && (upd.ip_total_len >= hdr_len_wide)
                  && (upd.ip_total_len <= avail)
                  && upd.ip_source_ok;

    assign arp_ok = (upd.byte_count >= gfaf_pkg::ARP_MIN_FRAME) && upd.arp_checks_ok;

    assign verdict_ok = filter_enable_reg
                     && (pass_mark_reg != '0)
                     && (upd.byte_count >= gfaf_pkg::ETH_HDR_BYTES)
                     && upd.mac_checks_ok
                     && (((upd.ether_kind == gfaf_pkg::KIND_IPV4) && ipv4_ok)
                      || ((upd.ether_kind == gfaf_pkg::KIND_ARP) && arp_ok));

    // frame state clears after the last byte
    always_comb
    begin
        state_next = state_reg;
        if (in_advance)
        begin
            if (in_last_reg)
                state_next = gfaf_pkg::FRAME_CLEAR;
            else
                state_next = upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= gfaf_pkg::FRAME_CLEAR;
        else
            state_reg <= state_next;
    end

    // verdict register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (verdict.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_advance && in_last_reg)
        begin
            out_accept_reg <= verdict_ok;
            out_mark_reg   <= verdict_ok ? pass_mark_reg : '0;
        end
    end

    assign verdict.valid      = out_valid_reg;
    assign verdict.accept     = out_accept_reg;
    assign verdict.frame_mark = out_mark_reg;

endmodule
`default_nettype wire
